// ----- hw/rtl/uer_pkg.sv -----
// shared types and constants for the ultrasonic echo ranger
// no dependencies; used by the interfaces, uer_core and the top level
package uer_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int SPEED_W          = 10;
  localparam int TRIG_W           = 8;
  localparam int TIMEOUT_W        = 16;
  localparam int DIST_W           = 25;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 16;

  localparam logic [SPEED_W-1:0]   SPEED_RST   = SPEED_W'(343);
  localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(10);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(30000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOUND_SPEED = 2'd0,
    CFG_TRIG_TICKS  = 2'd1,
    CFG_TIMEOUT     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_TRIG      = 2'd1,
    PH_WAIT_RISE = 2'd2,
    PH_MEASURE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } uer_in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DIST_W-1:0] distance_um;
  } uer_out_t;

  typedef struct packed {
    logic [SPEED_W-1:0]   sound_speed_mps;
    logic [TRIG_W-1:0]    trigger_ticks;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } uer_cfg_t;

endpackage

// ----- hw/rtl/uer_if.sv -----
// valid/ready stream interfaces for the ranger input and result words
// depends on uer_pkg
interface uer_in_if
  import uer_pkg::*;
  ();
  logic    valid;
  logic    ready;
  uer_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uer_out_if
  import uer_pkg::*;
  ();
  logic     valid;
  logic     ready;
  uer_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/uer_core.sv -----
// measurement state machine, tick counters and distance scaling
// depends on uer_pkg; instantiated by ultrasonic_echo_ranger_unit
module uer_core
  import uer_pkg::*;
#(
  parameter int CounterBits = COUNTER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  uer_in_t  in_word,
  input  uer_cfg_t cfg,
  output uer_out_t res
);

  localparam int CW = (CounterBits > TIMEOUT_W) ? CounterBits : TIMEOUT_W;
  localparam int PW = CounterBits + SPEED_W;
  localparam int HW = PW - 1;
  localparam int SW = (HW > DIST_W) ? HW : DIST_W;
  localparam logic [CounterBits-1:0] CNT_MAX = {CounterBits{1'b1}};
  localparam logic [SW-1:0] DIST_MAX = SW'({DIST_W{1'b1}});

  phase_t                  phase_r, phase_nxt;
  logic [TRIG_W-1:0]       trig_cnt_r, trig_cnt_nxt;
  logic [CounterBits-1:0]  elapsed_r, elapsed_nxt;
  logic [CounterBits-1:0]  width_r, width_nxt;
  logic                    last_echo_r;

  logic                    rising;
  logic [TRIG_W-1:0]       trig_cnt_inc;
  logic [CounterBits-1:0]  elapsed_inc;
  logic [CounterBits-1:0]  width_inc;
  logic                    expired;
  logic [PW-1:0]           product;
  logic [SW-1:0]           half_ext;
  logic [DIST_W-1:0]       dist_sat;

  assign rising       = in_word.echo_level && !last_echo_r;
  assign trig_cnt_inc = trig_cnt_r + TRIG_W'(1);
  assign elapsed_inc  = (elapsed_r == CNT_MAX) ? elapsed_r : elapsed_r + CounterBits'(1);
  assign width_inc    = (width_r == CNT_MAX) ? width_r : width_r + CounterBits'(1);
  assign expired      = (CW'(elapsed_inc) >= CW'(cfg.timeout_ticks)) ||
                        (elapsed_inc == CNT_MAX);

  assign product  = PW'(width_r) * PW'(cfg.sound_speed_mps);
  assign half_ext = SW'(product[PW-1:1]);
  assign dist_sat = (half_ext > DIST_MAX) ? {DIST_W{1'b1}} : half_ext[DIST_W-1:0];

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    trig_cnt_nxt = trig_cnt_r;
    elapsed_nxt  = elapsed_r;
    width_nxt    = width_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_word.start_req) begin
          trig_cnt_nxt = TRIG_W'(1);
          phase_nxt    = (TRIG_W'(1) >= cfg.trigger_ticks) ? PH_WAIT_RISE : PH_TRIG;
          elapsed_nxt  = '0;
          width_nxt    = '0;
        end
      end
      PH_TRIG: begin
        trig_cnt_nxt = trig_cnt_inc;
        if (trig_cnt_inc == '0 || trig_cnt_inc >= cfg.trigger_ticks) begin
          phase_nxt   = PH_WAIT_RISE;
          elapsed_nxt = '0;
        end
      end
      PH_WAIT_RISE: begin
        elapsed_nxt = elapsed_inc;
        if (expired) begin
          phase_nxt = PH_IDLE;
        end else if (rising) begin
          width_nxt = CounterBits'(1);
          phase_nxt = PH_MEASURE;
        end
      end
      PH_MEASURE: begin
        elapsed_nxt = elapsed_inc;
        if (!in_word.echo_level || expired) begin
          phase_nxt = PH_IDLE;
        end else begin
          width_nxt = width_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // result word
  always_comb begin
    res = '0;
    unique case (phase_r)
      PH_IDLE: begin
        res.trigger_level = in_word.start_req;
      end
      PH_TRIG: begin
        res.trigger_level = 1'b1;
      end
      PH_WAIT_RISE: begin
        res.timed_out = expired;
      end
      PH_MEASURE: begin
        res.done_res    = !in_word.echo_level;
        res.timed_out   = in_word.echo_level && expired;
        res.distance_um = in_word.echo_level ? '0 : dist_sat;
      end
      default: begin
        res = '0;
      end
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      trig_cnt_r  <= '0;
      elapsed_r   <= '0;
      width_r     <= '0;
      last_echo_r <= 1'b0;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      trig_cnt_r  <= trig_cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      width_r     <= width_nxt;
      last_echo_r <= in_word.echo_level;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.done_res |=> phase_r == PH_IDLE)
    else $error("measurement finished but block not idle");

  a_done_from_measure: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> phase_r == PH_MEASURE)
    else $error("done outside measurement");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(phase_r) && $stable(elapsed_r) && $stable(width_r))
    else $error("state moved without an accepted word");

  a_dist_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    res.distance_um != '0 |-> res.done_res)
    else $error("distance without done");

  a_timeout_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.timed_out |=> phase_r == PH_IDLE && !$past(res.done_res))
    else $error("timeout did not end the measurement");

endmodule

// ----- hw/rtl/ultrasonic_echo_ranger_unit.sv -----
// Ultrasonic echo pulse-width rangefinder, top level.
// depends on uer_pkg, uer_if and uer_core
//
// Usage:
//   in_chan carries one word per microsecond tick: start_req and the sampled
//   echo pin level. Every accepted input word yields exactly one result word
//   on out_chan: trigger pin level, busy, done, timeout and the distance in
//   micrometres (valid with done, zero otherwise).
//   cfg_we/cfg_idx/cfg_wdata write sound speed, trigger length and timeout;
//   write them only while no measurement is running.
// Latency and throughput:
//   one word per clock while out_chan is ready; the result of a word appears
//   on out_chan the cycle after it is accepted, from a single output register.
//   The distance is one width-by-speed multiply between state and that register.
// Reset:
//   synchronous, active low; the block goes idle, counters clear and the
//   config registers return to 343 m/s, 10 ticks and 30000 ticks.
// Stalls:
//   while a result waits with out_chan.ready low, in_chan.ready drops and
//   the state holds; ready returns in the cycle the result is taken.
module ultrasonic_echo_ranger_unit
  import uer_pkg::*;
#(
  parameter int CounterBits = COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  uer_in_if.sink                in_chan,
  uer_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  uer_cfg_t cfg_r;
  uer_out_t core_res;
  uer_out_t out_word_r;
  logic     out_valid_r, out_valid_nxt;
  logic     adv;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign adv           = in_chan.valid && in_chan.ready;
  assign out_valid_nxt = adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

  uer_core #(
    .CounterBits(CounterBits)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_word (in_chan.data),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sound_speed_mps <= SPEED_RST;
      cfg_r.trigger_ticks   <= TRIG_RST;
      cfg_r.timeout_ticks   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SOUND_SPEED: cfg_r.sound_speed_mps <= cfg_wdata[SPEED_W-1:0];
        CFG_TRIG_TICKS:  cfg_r.trigger_ticks   <= cfg_wdata[TRIG_W-1:0];
        CFG_TIMEOUT:     cfg_r.timeout_ticks   <= cfg_wdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= core_res;
    end
  end

endmodule
